// File: sv/eap_pkg.sv
// ----------------------------------------------------------------------------
// Easing animation progress package
// Register indexes, request kinds, curve codes and the sequencer states that
// are shared by the files of the block.
// ----------------------------------------------------------------------------
package eap_pkg;

	// Configuration register indexes.
	localparam logic REG_DURATION = 1'b0;
	localparam logic REG_CURVE    = 1'b1;

	// Request kinds carried in the input word's user bit.
	localparam logic REQ_TICK    = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	// Easing curve codes.
	localparam logic [2:0] CURVE_LINEAR      = 3'd0;
	localparam logic [2:0] CURVE_IN_QUAD     = 3'd1;
	localparam logic [2:0] CURVE_OUT_QUAD    = 3'd2;
	localparam logic [2:0] CURVE_INOUT_QUAD  = 3'd3;
	localparam logic [2:0] CURVE_IN_CUBIC    = 3'd4;
	localparam logic [2:0] CURVE_OUT_CUBIC   = 3'd5;
	localparam logic [2:0] CURVE_INOUT_CUBIC = 3'd6;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EVAL = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_MUL1 = 7'b0001000,
		ST_MUL2 = 7'b0010000,
		ST_MUL3 = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

// File: sv/eap_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider that forms floor(num * 2^FRAC_BITS / den) for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eap_div #(
	parameter int TIME_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TIME_WIDTH-1:0] num,
	input  logic [TIME_WIDTH-1:0] den,
	output logic                  busy,
	output logic [FRAC_BITS-1:0]  quot
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [TIME_WIDTH-1:0] rem_q;
	logic [TIME_WIDTH-1:0] den_q;
	logic [FRAC_BITS-1:0]  quot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_WIDTH:0]   rem2;
	logic [TIME_WIDTH:0]   diff;
	logic                  ge;

	// One restoring step: double the remainder and try to take the divisor.
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};

	// The count of remaining steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(FRAC_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[TIME_WIDTH-1:0] : rem2[TIME_WIDTH-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

// File: sv/eap_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Shared multiplier with a registered result: p = floor(a * b / 2^FRAC_BITS)
// for operands in 0..1.0.
// ----------------------------------------------------------------------------
module eap_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [FRAC_BITS:0] a,
	input  logic [FRAC_BITS:0] b,
	output logic [FRAC_BITS:0] p
);

	logic [2*FRAC_BITS+1:0] prod;
	logic [FRAC_BITS:0]     p_q;

	// The product of two values no larger than 1.0 stays no larger than 1.0.
	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod[2*FRAC_BITS:FRAC_BITS];
		end
	end

	assign p = p_q;

endmodule

// File: sv/easing_animation_progress.sv
// ----------------------------------------------------------------------------
// Easing animation progress
// Keeps a saturating elapsed-time register, divides it by the duration and
// applies one of seven easing curves, giving an unsigned Q1.FRAC_BITS value.
//
//   Channel   Signals                          Word
//   input     s_tvalid s_tready s_tdata s_tuser  delta_time, request kind
//   output    m_tvalid m_tready m_tdata m_tuser  eased_value, finished flag
//   config    cfg_we cfg_addr cfg_wdata          duration, curve
//
// A restart, a zero duration or a saturating tick goes from the evaluation
// state straight to the done state and then into the output register. Other
// ticks pass through the one-bit-per-cycle divider and then, for quadratic and
// cubic curves, through one or two passes of the shared multiplier. The input
// is ready again as soon as the result has been placed in the output register;
// that register holds while m_tready is low and stalls the sequencer.
// Reset clears the elapsed time and both configuration registers.
// ----------------------------------------------------------------------------
module easing_animation_progress
	import eap_pkg::*;
#(
	parameter int TIME_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input channel.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((TIME_WIDTH+7)/8)*8-1:0]       s_tdata,  // delta_time
	input  logic                                  s_tuser,  // req_type
	// Output channel.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((FRAC_BITS+1+7)/8)*8-1:0]      m_tdata,  // eased_value
	output logic                                  m_tuser,  // finished
	// Configuration port.
	input  logic                                  cfg_we,
	input  logic                                  cfg_addr,
	input  logic [TIME_WIDTH-1:0]                 cfg_wdata
);

	localparam int OUT_DW = ((FRAC_BITS + 1 + 7) / 8) * 8;
	localparam logic [FRAC_BITS:0] FIX_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	state_t                state_q;
	logic [TIME_WIDTH-1:0] duration_q;
	logic [2:0]            curve_q;
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic                  req_q;
	logic [TIME_WIDTH-1:0] delta_q;
	logic [FRAC_BITS:0]    res_q;
	logic                  res_fin_q;
	logic [FRAC_BITS:0]    out_value_q;
	logic                  out_fin_q;
	logic                  out_valid_q;

	logic [TIME_WIDTH-1:0] remain;
	logic [TIME_WIDTH-1:0] elapsed_sum;
	logic                  saturate;
	logic                  div_start;
	logic                  div_busy;
	logic [FRAC_BITS-1:0]  t;
	logic                  lower_half;
	logic                  is_cubic;
	logic                  is_in;
	logic                  is_out;
	logic                  is_linear;
	logic                  use_t;
	logic [FRAC_BITS:0]    x;
	logic                  mul_en;
	logic [FRAC_BITS:0]    mul_a;
	logic [FRAC_BITS:0]    mul_p;
	logic [FRAC_BITS:0]    shaped;
	logic                  out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= '0;
			curve_q    <= CURVE_LINEAR;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DURATION: duration_q <= cfg_wdata;
				REG_CURVE:    curve_q    <= cfg_wdata[2:0];
				default:      ;
			endcase
		end
	end

	// Saturation test against the time left.
	assign remain      = duration_q - elapsed_q;
	assign saturate    = (elapsed_q >= duration_q) || (delta_q >= remain);
	assign elapsed_sum = elapsed_q + delta_q;
	assign div_start   = (state_q == ST_EVAL) && (req_q == REQ_TICK) &&
	                     (duration_q != '0) && !saturate;

	eap_div #(
		.TIME_WIDTH (TIME_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed_sum),
		.den    (duration_q),
		.busy   (div_busy),
		.quot   (t)
	);

	// Curve classification and the base operand (t or 1 - t).
	always_comb begin
		is_linear  = !(curve_q inside {CURVE_IN_QUAD, CURVE_OUT_QUAD, CURVE_INOUT_QUAD,
		                               CURVE_IN_CUBIC, CURVE_OUT_CUBIC, CURVE_INOUT_CUBIC});
		is_cubic   = curve_q inside {CURVE_IN_CUBIC, CURVE_OUT_CUBIC, CURVE_INOUT_CUBIC};
		is_in      = curve_q inside {CURVE_IN_QUAD, CURVE_IN_CUBIC};
		is_out     = curve_q inside {CURVE_OUT_QUAD, CURVE_OUT_CUBIC};
		lower_half = !t[FRAC_BITS-1];
		use_t      = is_in || (!is_out && lower_half);
		x          = use_t ? {1'b0, t} : FIX_ONE - {1'b0, t};
	end

	// Multiplier operands: x * x first, then the square times x for cubics.
	assign mul_en = (state_q == ST_MUL1) || ((state_q == ST_MUL2) && is_cubic);
	assign mul_a  = (state_q == ST_MUL2) ? mul_p : x;

	eap_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (x),
		.p   (mul_p)
	);

	// Final shaping of the power of x into the curve value.
	always_comb begin
		if (is_in) begin
			shaped = mul_p;
		end else if (is_out) begin
			shaped = FIX_ONE - mul_p;
		end else if (lower_half) begin
			shaped = is_cubic ? (mul_p << 2) : (mul_p << 1);
		end else begin
			shaped = FIX_ONE - (is_cubic ? (mul_p << 2) : (mul_p << 1));
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// Sequencer and elapsed-time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			elapsed_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (req_q == REQ_RESTART) begin
						elapsed_q <= '0;
						state_q   <= ST_DONE;
					end else if (duration_q == '0) begin
						state_q <= ST_DONE;
					end else if (saturate) begin
						elapsed_q <= duration_q;
						state_q   <= ST_DONE;
					end else begin
						elapsed_q <= elapsed_sum;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= is_linear ? ST_DONE : ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= is_cubic ? ST_MUL3 : ST_DONE;
				ST_MUL3: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q   <= s_tuser;
			delta_q <= s_tdata[TIME_WIDTH-1:0];
		end
	end

	// Pending result of the item at work.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EVAL: begin
				res_q     <= (req_q == REQ_RESTART) ? '0 : FIX_ONE;
				res_fin_q <= req_q != REQ_RESTART;
			end
			ST_DIV: begin
				res_q     <= {1'b0, t};
				res_fin_q <= 1'b0;
			end
			ST_MUL2: begin
				if (!is_cubic) begin
					res_q <= shaped;
				end
			end
			ST_MUL3: res_q <= shaped;
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_value_q <= res_q;
			out_fin_q   <= res_fin_q;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'(out_value_q);
	assign m_tuser  = out_fin_q;

endmodule

// File: verif/easing_progress_checker.sv
// ----------------------------------------------------------------------------
// Easing animation progress checker
// Watches the configuration port and both stream channels of the block. It
// keeps its own elapsed time, duration and curve, works out the eased value
// and finished flag for every accepted input word, and compares each output
// word with the oldest value still due. Failures are counted for the top.
// ----------------------------------------------------------------------------
module easing_progress_checker
	import eap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // delta_time
	input  logic        s_tuser,   // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // eased_value, zero padded
	input  logic        m_tuser,   // finished
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata,
	output int          fails = 0,
	output int          pending = 0
);

	localparam logic [16:0] FIX_ONE  = 17'd65536;
	localparam logic [16:0] FIX_HALF = 17'd32768;

	typedef struct packed {
		logic [16:0] eased;
		logic        finished;
	} progress_t;

	// Shadow copies of the block's registers and state.
	logic [31:0] span_ms    = '0;
	logic [2:0]  curve      = CURVE_LINEAR;
	logic [31:0] elapsed_ms = '0;

	progress_t progress_due[$];

	// Fixed-point product with the fraction bits dropped.
	function automatic logic [16:0] q16_mul(logic [16:0] a, logic [16:0] b);
		logic [33:0] p;
		p = 34'(a) * 34'(b);
		return 17'(p >> 16);
	endfunction

	// Restoring division giving floor(num * 2^16 / den); num is below den.
	function automatic logic [16:0] elapsed_fraction(logic [31:0] num, logic [31:0] den);
		logic [32:0] rem;
		logic [32:0] gap;
		logic [15:0] q;
		rem = {1'b0, num};
		q = '0;
		for (int i = 0; i < 16; i++) begin
			gap = {1'b0, den} - rem;
			q = q << 1;
			if (rem >= gap) begin
				rem = rem - gap;
				q[0] = 1'b1;
			end else begin
				rem = rem + rem;
			end
		end
		return {1'b0, q};
	endfunction

	// Applies the selected curve to the fraction; an unknown code is linear.
	function automatic logic [16:0] curve_value(logic [16:0] t);
		logic [16:0] u;
		u = FIX_ONE - t;
		case (curve)
			CURVE_IN_QUAD: begin
				return q16_mul(t, t);
			end
			CURVE_OUT_QUAD: begin
				return FIX_ONE - q16_mul(u, u);
			end
			CURVE_INOUT_QUAD: begin
				if (t < FIX_HALF)
					return q16_mul(t, t) << 1;
				return FIX_ONE - (q16_mul(u, u) << 1);
			end
			CURVE_IN_CUBIC: begin
				return q16_mul(q16_mul(t, t), t);
			end
			CURVE_OUT_CUBIC: begin
				return FIX_ONE - q16_mul(q16_mul(u, u), u);
			end
			CURVE_INOUT_CUBIC: begin
				if (t < FIX_HALF)
					return q16_mul(q16_mul(t, t), t) << 2;
				return FIX_ONE - (q16_mul(q16_mul(u, u), u) << 2);
			end
			default: begin
				return t;
			end
		endcase
	endfunction

	// Advances the shadow elapsed time by one word and gives its result.
	function automatic progress_t progress_after(logic kind, logic [31:0] delta);
		progress_t res;
		if (kind == REQ_RESTART) begin
			elapsed_ms = '0;
			res = '{eased: '0, finished: 1'b0};
		end else if (span_ms == 0) begin
			res = '{eased: FIX_ONE, finished: 1'b1};
		end else if (elapsed_ms >= span_ms || delta >= span_ms - elapsed_ms) begin
			elapsed_ms = span_ms;
			res = '{eased: FIX_ONE, finished: 1'b1};
		end else begin
			elapsed_ms = elapsed_ms + delta;
			res.eased = curve_value(elapsed_fraction(elapsed_ms, span_ms));
			res.finished = 1'b0;
		end
		return res;
	endfunction

	// Output words are matched first, so a word can never meet the value of
	// an input word taken at the same edge.
	always @(posedge clk) begin
		progress_t due;
		if (!arst_n) begin
			span_ms = '0;
			curve = CURVE_LINEAR;
			elapsed_ms = '0;
			progress_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (progress_due.size() == 0) begin
					fails++;
					$display("%0t: output word with nothing due: eased_value %0d finished %0d",
						$time, m_tdata, m_tuser);
				end else begin
					due = progress_due.pop_front();
					if (m_tdata !== {7'd0, due.eased}) begin
						fails++;
						$display("%0t: eased_value expected %0d actual %0d",
							$time, due.eased, m_tdata);
					end
					if (m_tuser !== due.finished) begin
						fails++;
						$display("%0t: finished expected %0d actual %0d",
							$time, due.finished, m_tuser);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_DURATION)
					span_ms = cfg_wdata;
				else
					curve = cfg_wdata[2:0];
			end
			if (s_tvalid && s_tready)
				progress_due.push_back(progress_after(s_tuser, s_tdata));
		end
		pending = progress_due.size();
	end

endmodule

// File: verif/easing_animation_progress_tb.sv
// ----------------------------------------------------------------------------
// Easing animation progress testbench
// Drives restart and tick words into the block with random gaps while the
// output side stalls at random, twice for a long stretch. A short directed
// run covers zero and full durations, saturation, lowered durations and the
// unused curve code; random phases then sweep every curve over many
// durations, most of them as restart-then-ramp sequences. The checker beside
// the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module easing_animation_progress_tb;
	import eap_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;  // delta_time
	logic        s_tuser   = REQ_TICK;  // req_type
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;  // eased_value, zero padded
	logic        m_tuser;  // finished
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = REG_DURATION;
	logic [31:0] cfg_wdata = '0;

	int fails;
	int pending;
	int gap_max = 0;

	always #2 clk = ~clk;

	easing_animation_progress DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	easing_progress_checker progress_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	// Offers one word after a random gap and returns at the falling edge
	// after it was taken, with valid still high.
	task automatic send_word(input logic kind, input logic [31:0] delta);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= delta;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Holds a register write across the next rising edge; the caller lowers the enable.
	task automatic set_reg(input logic idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// Output side: random stalls per word, quiet stretches, and two long
	// hold-offs that back the block up into its input.
	initial begin
		int hold;
		int taken;
		int rx_max;
		taken = 0;
		rx_max = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: rx_max = 0;
					1: rx_max = 3;
					default: rx_max = 10;
				endcase
			end
			hold = (taken == 200 || taken == 520) ? 400 : $urandom_range(0, rx_max);
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
			taken++;
		end
	end

	// Stimulus and verdict.
	initial begin
		int sent;
		int n;
		int r;
		logic [31:0] dur;
		logic [31:0] step;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero duration after reset, then a restart with a full delta.
		send_word(REQ_TICK, 32'd0);
		send_word(REQ_TICK, 32'hFFFF_FFFF);
		send_word(REQ_RESTART, 32'hFFFF_FFFF);

		// Linear ramp over 1000 ms through the midpoint into saturation.
		drain();
		set_reg(REG_DURATION, 32'd1000);
		set_reg(REG_CURVE, 32'(CURVE_LINEAR));
		cfg_we <= 1'b0;
		send_word(REQ_TICK, 32'd0);
		send_word(REQ_TICK, 32'd250);
		send_word(REQ_TICK, 32'd249);
		send_word(REQ_TICK, 32'd2);
		send_word(REQ_RESTART, 32'd0);
		send_word(REQ_TICK, 32'd999);
		send_word(REQ_TICK, 32'd1);
		send_word(REQ_TICK, 32'd0);

		// Duration lowered below the elapsed time.
		send_word(REQ_RESTART, 32'd77);
		send_word(REQ_TICK, 32'd800);
		drain();
		set_reg(REG_DURATION, 32'd500);
		cfg_we <= 1'b0;
		send_word(REQ_TICK, 32'd0);

		// Full-range duration with the in-out cubic curve.
		drain();
		set_reg(REG_DURATION, 32'hFFFF_FFFF);
		set_reg(REG_CURVE, 32'(CURVE_INOUT_CUBIC));
		cfg_we <= 1'b0;
		send_word(REQ_RESTART, 32'd0);
		send_word(REQ_TICK, 32'h7FFF_FFFF);
		send_word(REQ_TICK, 32'd1);
		send_word(REQ_TICK, 32'hFFFF_FFFE);

		// Unused curve code behaves as linear.
		drain();
		set_reg(REG_DURATION, 32'd3);
		set_reg(REG_CURVE, 32'(3'b111));
		cfg_we <= 1'b0;
		send_word(REQ_RESTART, 32'd5);
		send_word(REQ_TICK, 32'd1);
		send_word(REQ_TICK, 32'd1);
		send_word(REQ_TICK, 32'd1);

		// Random phases: a new duration and curve each, mostly a restart
		// followed by a ramp of ticks scaled to the duration.
		sent = 0;
		for (int phase = 0; sent < 700; phase++) begin
			drain();
			case ($urandom_range(0, 9))
				0: dur = 32'd0;
				1: dur = 32'd1;
				2: dur = 32'hFFFF_FFFF;
				3, 4, 5: dur = $urandom_range(2, 64);
				6, 7, 8: dur = $urandom_range(65, 100000);
				default: dur = $urandom;
			endcase
			set_reg(REG_DURATION, dur);
			set_reg(REG_CURVE, 32'(phase % 8));
			cfg_we <= 1'b0;
			case ($urandom_range(0, 3))
				0: gap_max = 0;
				1: gap_max = 2;
				2: gap_max = 5;
				default: gap_max = 10;
			endcase
			step = dur / $urandom_range(3, 40);
			if (step == 0)
				step = 1;
			if ($urandom_range(0, 3) != 0) begin
				send_word(REQ_RESTART, $urandom);
				sent++;
			end
			n = $urandom_range(10, 40);
			repeat (n) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					send_word(REQ_RESTART, $urandom);
				else if (r == 1)
					send_word(REQ_TICK, $urandom);
				else if (r == 2)
					send_word(REQ_TICK, 32'd0);
				else
					send_word(REQ_TICK, $urandom_range(0, step));
				sent++;
			end
		end

		drain();
		repeat (40) @(negedge clk);
		if (fails == 0)
			$display("easing_animation_progress test passed");
		else
			$display("easing_animation_progress test failed");
		$finish;
	end

	// Run limit, many times the slowest correct run.
	initial begin
		#2000000;
		$display("easing_animation_progress test failed");
		$finish;
	end

endmodule

// File: files.f
sv/eap_pkg.sv
sv/eap_div.sv
sv/eap_mul.sv
sv/easing_animation_progress.sv
verif/easing_progress_checker.sv
verif/easing_animation_progress_tb.sv
